/* hdl/spq_pkg.sv */
// Package for the sorted priority queue: beat structs, entry layout, codes.
// No dependencies.
`default_nettype none
package spq_pkg;

  localparam int unsigned SPQ_CAPACITY = 16;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] item_data;
    logic [15:0]        item_priority;
  } spq_cmd_t;

  typedef struct packed {
    logic signed [31:0] head_data;
    logic [15:0]        head_priority;
    logic [1:0]         status;
    logic [4:0]         fill_count;
  } spq_result_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [15:0]        priority_val;
  } spq_entry_t;

endpackage
`default_nettype wire

/* hdl/sorted_priority_queue_core.sv */
// Sorted priority queue top: ring buffer of entries in spq_entry_mem, kept in
// ascending priority order by a sequencer with one shared priority compare.
// Insert alternates S_INS_RD and S_INS_CMP for each entry moved back; remove/peek
// read the head in S_HD_CMP; full insert, empty read and unused mode answer from idle.
// Throughput: one item at a time, busy holds until done; the receiver cannot stall.
// Reset (async, active low) empties the queue; entry storage is not cleared.
`default_nettype none
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = SPQ_CAPACITY
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output logic       busy,
  input  wire spq_cmd_t cmd_i,
  output logic       result_valid_o,
  output spq_result_t result_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_INS_RD  = 2'd1;
  localparam logic [1:0] S_INS_CMP = 2'd2;
  localparam logic [1:0] S_HD_CMP  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d, wr_q, wr_d;
  logic [CW-1:0] count_q, count_d, rem_q, rem_d;
  spq_cmd_t      item_q, item_d;
  logic          res_valid_q, res_valid_d;
  spq_result_t   res_q, res_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, wr_prev;
  spq_entry_t    mem_wdata, mem_rdata, new_entry;
  logic          moves_back;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST : p - AW'(1);
  endfunction

  spq_entry_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign wr_prev    = ptr_prev(wr_q);
  assign new_entry  = '{data: item_q.item_data, priority_val: item_q.item_priority};
  // shared compare: held entry strictly later than the new one
  assign moves_back = mem_rdata.priority_val > item_q.item_priority;
  assign busy       = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    wr_d        = wr_q;
    count_d     = count_q;
    rem_d       = rem_q;
    item_d      = item_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_q;
    mem_wdata   = new_entry;
    mem_raddr   = head_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d = '{head_data: '0, head_priority: '0, status: ST_OK,
                    fill_count: 5'(count_q)};
          case (cmd_i.mode)
            MODE_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                res_d.status = ST_FULL;
                res_valid_d  = 1'b1;
              end else begin
                item_d  = cmd_i;
                wr_d    = tail_q;
                rem_d   = count_q;
                state_d = S_INS_RD;
              end
            end
            MODE_REMOVE, MODE_PEEK: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                res_valid_d  = 1'b1;
              end else begin
                item_d  = cmd_i;
                state_d = S_HD_CMP;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        mem_raddr = wr_prev;
        if (rem_q == '0) begin
          mem_we           = 1'b1;
          tail_d           = ptr_next(tail_q);
          count_d          = count_q + CW'(1);
          res_d.fill_count = 5'(count_q + CW'(1));
          res_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (moves_back) begin
          mem_wdata = mem_rdata;
          wr_d      = wr_prev;
          rem_d     = rem_q - CW'(1);
          state_d   = S_INS_RD;
        end else begin
          tail_d           = ptr_next(tail_q);
          count_d          = count_q + CW'(1);
          res_d.fill_count = 5'(count_q + CW'(1));
          res_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_HD_CMP: begin
        res_d.head_data     = mem_rdata.data;
        res_d.head_priority = mem_rdata.priority_val;
        if (item_q.mode == MODE_REMOVE) begin
          head_d           = ptr_next(head_q);
          count_d          = count_q - CW'(1);
          res_d.fill_count = 5'(count_q - CW'(1));
        end
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q   <= wr_d;
    rem_q  <= rem_d;
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_done_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("sequencer finished without a result beat");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> busy)
    else $error("entry write while idle");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

endmodule
`default_nettype wire

/* hdl/spq_entry_mem.sv */
// Entry storage: one write port, one read port with registered read data.
// Depends on spq_pkg.
`default_nettype none
module spq_entry_mem
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = SPQ_CAPACITY,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire spq_entry_t    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output spq_entry_t         rdata_o
);

  spq_entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* dv/sorted_priority_queue_core_test.sv */
// Testbench for sorted_priority_queue_core: command beats are checked against a
// sorted-list predictor of the queue, result by result, in order.
// Depends on spq_pkg and the sorted_priority_queue_core RTL.
`default_nettype none
module sorted_priority_queue_core_test;
  import spq_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  spq_cmd_t    cmd_i = '0;
  logic        result_valid_o;
  spq_result_t result_o;

  spq_entry_t  model_q[SPQ_CAPACITY];
  int unsigned model_count = 0;
  spq_result_t pending_results[$];

  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_drops = 0;
  int unsigned n_empty_reads = 0;
  int unsigned n_heads = 0;
  int unsigned insert_pct = 70;

  sorted_priority_queue_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic spq_result_t queue_step(spq_cmd_t c);
    spq_result_t r;
    int unsigned pos;
    int unsigned i;
    r = '0;
    r.status = ST_OK;
    case (c.mode)
      MODE_INSERT: begin
        if (model_count >= SPQ_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < model_count && model_q[pos].priority_val <= c.item_priority) pos++;
          for (i = model_count; i > pos; i--) model_q[i] = model_q[i-1];
          model_q[pos].data = c.item_data;
          model_q[pos].priority_val = c.item_priority;
          model_count++;
        end
      end
      MODE_REMOVE, MODE_PEEK: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_data = model_q[0].data;
          r.head_priority = model_q[0].priority_val;
          if (c.mode == MODE_REMOVE) begin
            for (i = 1; i < model_count; i++) model_q[i-1] = model_q[i];
            model_count--;
          end
        end
      end
      default: ;
    endcase
    r.fill_count = 5'(model_count);
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0h, expected %0h", n_checked, name, got, want));
  endtask

  always @(posedge clk_i) begin
    spq_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result %p", result_o));
      end else begin
        want = pending_results.pop_front();
        check_field("head_data", result_o.head_data, want.head_data);
        check_field("head_priority", 32'(result_o.head_priority), 32'(want.head_priority));
        check_field("status", 32'(result_o.status), 32'(want.status));
        check_field("fill_count", 32'(result_o.fill_count), 32'(want.fill_count));
        case (want.status)
          ST_FULL:  n_drops++;
          ST_EMPTY: n_empty_reads++;
          default:  if (want.head_priority != 0 || want.head_data != 0) n_heads++;
        endcase
      end
      n_checked++;
    end
  end

  task automatic send_cmd(input logic [1:0] mode, input logic [31:0] data, input logic [15:0] pri);
    spq_cmd_t c;
    c.mode = mode;
    c.item_data = data;
    c.item_priority = pri;
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(queue_step(c));
    n_sent++;
  endtask

  task automatic idle_gap(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_priority();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(7));
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_empty_reads();
    send_cmd(MODE_REMOVE, 32'h1234_5678, 16'h00FF);
    send_cmd(MODE_PEEK, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(MODE_NOP, 32'hDEAD_BEEF, 16'hA5A5);
  endtask

  task automatic test_insert_order();
    send_cmd(MODE_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
    send_cmd(MODE_INSERT, 32'h8000_0000, 16'h0000);
    send_cmd(MODE_INSERT, 32'hFFFF_FFFF, 16'h0000);
    send_cmd(MODE_INSERT, 32'h0000_0000, 16'hFFFF);
    send_cmd(MODE_INSERT, 32'h5555_5555, 16'h8000);
    send_cmd(MODE_INSERT, 32'hAAAA_AAAA, 16'h7FFF);
    send_cmd(MODE_NOP, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(MODE_PEEK, 32'h0, 16'h0);
    repeat (7) send_cmd(MODE_REMOVE, $urandom, 16'($urandom));
  endtask

  task automatic test_full_queue();
    repeat (SPQ_CAPACITY) send_cmd(MODE_INSERT, $urandom, 16'($urandom_range(3)));
    send_cmd(MODE_INSERT, $urandom, 16'h0000);
    send_cmd(MODE_INSERT, $urandom, 16'hFFFF);
    send_cmd(MODE_PEEK, $urandom, 16'($urandom));
    send_cmd(MODE_NOP, $urandom, 16'($urandom));
    repeat (SPQ_CAPACITY + 1) send_cmd(MODE_REMOVE, $urandom, 16'($urandom));
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct);
    int unsigned k;
    int unsigned run_left;
    int unsigned roll;
    logic [1:0] mode;
    run_left = 0;
    for (k = 0; k < n_items; k++) begin
      if (run_left == 0) begin
        insert_pct = (insert_pct > 50) ? 25 : 75;
        run_left = $urandom_range(16, 40);
      end
      run_left--;
      roll = $urandom_range(99);
      if (roll < insert_pct) mode = MODE_INSERT;
      else if (roll < insert_pct + (100 - insert_pct) * 2 / 3) mode = MODE_REMOVE;
      else if (roll < 95) mode = MODE_PEEK;
      else mode = MODE_NOP;
      send_cmd(mode, $urandom, random_priority());
      if (idle_pct != 0) idle_gap(idle_pct);
    end
  endtask

  initial begin
    int unsigned k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_reads();
    test_insert_order();
    test_full_queue();
    test_random_traffic(135, 32);
    wait_for_results();
    test_random_traffic(135, 67);
    test_random_traffic(135, 0);

    start <= 1'b0;
    for (k = 0; k < 10000 && pending_results.size() != 0; k++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("sent %0d commands, checked %0d results", n_sent, n_checked);
    $display("heads returned %0d, empty reads %0d, dropped full inserts %0d",
             n_heads, n_empty_reads, n_drops);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
